// File: hw/rtl/rbfi_pkg.sv
`default_nettype none
package rbfi_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int SIZE_W     = 31;
   // Origin after centring: 32-bit origin plus half of a 31-bit size.
   localparam int POS_W      = 34;
   // Face numerator (size - origin), one bit of headroom.
   localparam int NUM_W      = 35;
   localparam int DIVIDEND_W = NUM_W + FRAC_BITS;
   localparam int DIVISOR_W  = COORD_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
   localparam int PROD_W     = 2 * COORD_W;
   localparam int TEST_W     = PROD_W + 2;
   localparam int FACE_W     = 3;
   localparam int AXIS_W     = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [FACE_W-1:0] LAST_FACE = FACE_W'(5);

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRED = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

   // One ray after centring, as it waits in the queue.
   typedef struct packed {
      logic [2:0][POS_W-1:0]   pos;
      logic [2:0][COORD_W-1:0] dir;
   } ray_type;

   typedef struct packed {
      logic [2:0][SIZE_W-1:0] size;
   } box_type;

   function automatic logic [AXIS_W-1:0] next_axis(input logic [AXIS_W-1:0] a);
      next_axis = (a == AXIS_W'(2)) ? AXIS_W'(0) : a + AXIS_W'(1);
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rbfi_front.sv
`default_nettype none
module rbfi_front import rbfi_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [SIZE_W-1:0]      csr_wr_data,
   input  wire logic [6*COORD_W-1:0]   req_tdata,
   output ray_type                     ray,
   output box_type                     box
);

   logic [2:0][SIZE_W-1:0] size_ff;
   logic                   centred_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= {3{SIZE_RESET}};
         centred_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SIZE_X:  size_ff[0]  <= csr_wr_data;
            CSR_SIZE_Y:  size_ff[1]  <= csr_wr_data;
            CSR_SIZE_Z:  size_ff[2]  <= csr_wr_data;
            CSR_CENTRED: centred_ff  <= csr_wr_data[0];
            default:     centred_ff  <= centred_ff;
         endcase
      end
   end

   // Centring moves the ray origin by half the box size on each axis.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ray.dir[i] = req_tdata[i*COORD_W + 3*COORD_W +: COORD_W];
         ray.pos[i] = POS_W'($signed(req_tdata[i*COORD_W +: COORD_W]))
                    + (centred_ff ? POS_W'(size_ff[i][SIZE_W-1:1]) : POS_W'(0));
      end
      box.size = size_ff;
   end

endmodule
`default_nettype wire

// File: hw/rtl/rbfi_fifo.sv
`default_nettype none
module rbfi_fifo import rbfi_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire ray_type push_data,
   input  wire logic    pop,
   output ray_type      pop_data,
   output logic         full,
   output logic         empty
);

   ray_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;

endmodule
`default_nettype wire

// File: hw/rtl/rbfi_divider.sv
`default_nettype none
module rbfi_divider import rbfi_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVISOR_W:0]    rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;

   // Restoring division, one quotient bit per cycle.
   assign shifted = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= diff[DIVISOR_W+1] ? shifted : diff[DIVISOR_W:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], ~diff[DIVISOR_W+1]};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: hw/rtl/rbfi_back.sv
`default_nettype none
module rbfi_back import rbfi_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire box_type             box,
   input  wire ray_type             ray,
   input  wire logic                ray_empty,
   output logic                     ray_pop,
   output logic [COORD_W-1:0]       out_distance,
   output logic [FACE_W-1:0]        out_face,
   output logic                     out_hit,
   output logic                     out_last,
   output logic                     out_valid,
   input  wire logic                out_ready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SEL   = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_TEST  = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;

   logic [2:0]                state_ff, state_in;
   ray_type                   ray_ff;
   logic [FACE_W-1:0]         face_ff, face_in;
   logic                      neg_ff;
   logic [COORD_W-1:0]        t_ff;
   logic signed [PROD_W-1:0]  prod_b_ff, prod_c_ff;
   logic                      have_pend_ff, have_pend_in;
   logic [COORD_W-1:0]        pend_dist_ff;
   logic [FACE_W-1:0]         pend_face_ff;
   logic                      out_valid_ff;
   logic [COORD_W-1:0]        out_dist_ff;
   logic [FACE_W-1:0]         out_face_ff;
   logic                      out_hit_ff;
   logic                      out_last_ff;

   logic [AXIS_W-1:0]         ax_a, ax_b, ax_c;
   logic signed [COORD_W-1:0] dir_a;
   logic signed [NUM_W-1:0]   num;
   logic [NUM_W-1:0]          num_mag;
   logic [DIVISOR_W-1:0]      dir_mag;
   logic                      div_start, div_done;
   logic [DIVIDEND_W-1:0]     quotient;
   logic [COORD_W-1:0]        t_sat;
   logic signed [TEST_W-1:0]  q_b, q_c, lim_b, lim_c;
   logic                      hit, out_free, emit_pend, emit_flush;

   assign ax_a  = face_ff[FACE_W-1:1];
   assign ax_b  = next_axis(ax_a);
   assign ax_c  = next_axis(ax_b);
   assign dir_a = $signed(ray_ff.dir[ax_a]);

   // Numerator: minus the origin for the low face, size minus origin for the high one.
   assign num     = (face_ff[0] ? NUM_W'(box.size[ax_a]) : NUM_W'(0))
                  - NUM_W'($signed(ray_ff.pos[ax_a]));
   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign dir_mag = dir_a[COORD_W-1] ? DIVISOR_W'(-dir_a) : DIVISOR_W'(dir_a);

   assign div_start = state_ff == S_SEL && dir_a != '0;

   rbfi_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num_mag, FRAC_BITS'(0)}),
      .divisor  (dir_mag),
      .done     (div_done),
      .quotient (quotient)
   );

   // Saturate the truncated quotient to the signed 32-bit range.
   always_comb begin
      if (neg_ff) begin
         if ((|quotient[DIVIDEND_W-1:COORD_W])
             || (quotient[COORD_W-1] && |quotient[COORD_W-2:0])) begin
            t_sat = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            t_sat = COORD_W'(-quotient[COORD_W-1:0]);
         end
      end else begin
         if (|quotient[DIVIDEND_W-1:COORD_W-1]) begin
            t_sat = {1'b0, {(COORD_W-1){1'b1}}};
         end else begin
            t_sat = quotient[COORD_W-1:0];
         end
      end
   end

   // Exact half-open test of the hit point on the two other axes.
   assign q_b   = (TEST_W'($signed(ray_ff.pos[ax_b])) <<< FRAC_BITS)
                + TEST_W'(prod_b_ff);
   assign q_c   = (TEST_W'($signed(ray_ff.pos[ax_c])) <<< FRAC_BITS)
                + TEST_W'(prod_c_ff);
   assign lim_b = $signed(TEST_W'({box.size[ax_b], FRAC_BITS'(0)}));
   assign lim_c = $signed(TEST_W'({box.size[ax_c], FRAC_BITS'(0)}));
   assign hit   = !q_b[TEST_W-1] && (q_b < lim_b) && !q_c[TEST_W-1] && (q_c < lim_c);

   assign out_free   = !out_valid_ff || out_ready;
   assign emit_pend  = state_ff == S_TEST && hit && have_pend_ff && out_free;
   assign emit_flush = state_ff == S_FLUSH && out_free;
   assign ray_pop    = state_ff == S_IDLE && !ray_empty;

   always_comb begin
      state_in     = state_ff;
      face_in      = face_ff;
      have_pend_in = have_pend_ff;
      case (state_ff)
         S_IDLE: begin
            if (!ray_empty) begin
               state_in     = S_SEL;
               face_in      = '0;
               have_pend_in = 1'b0;
            end
         end
         S_SEL: begin
            if (dir_a != '0) begin
               state_in = S_WAIT;
            end else if (face_ff[0] || face_ff == LAST_FACE - FACE_W'(1)) begin
               // A zero direction skips both faces of the axis.
               if (ax_a == AXIS_W'(2)) begin
                  state_in = S_FLUSH;
               end else begin
                  face_in = {ax_a + AXIS_W'(1), 1'b0};
               end
            end else begin
               face_in = {ax_a + AXIS_W'(1), 1'b0};
               if (ax_a == AXIS_W'(2)) state_in = S_FLUSH;
            end
         end
         S_WAIT: begin
            if (div_done) state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            if (!hit || !have_pend_ff || out_free) begin
               if (hit) have_pend_in = 1'b1;
               if (face_ff == LAST_FACE) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_SEL;
                  face_in  = face_ff + FACE_W'(1);
               end
            end
         end
         S_FLUSH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_pend_ff <= have_pend_in;
         if (emit_pend || emit_flush) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      face_ff <= face_in;
      if (ray_pop) ray_ff <= ray;
      if (div_start) neg_ff <= num[NUM_W-1] ^ dir_a[COORD_W-1];
      if (div_done) t_ff <= t_sat;
      if (state_ff == S_MUL) begin
         prod_b_ff <= $signed(t_ff) * $signed(ray_ff.dir[ax_b]);
         prod_c_ff <= $signed(t_ff) * $signed(ray_ff.dir[ax_c]);
      end
      if (state_ff == S_TEST && hit && (!have_pend_ff || out_free)) begin
         pend_dist_ff <= t_ff;
         pend_face_ff <= face_ff;
      end
      if (emit_pend) begin
         out_dist_ff <= pend_dist_ff;
         out_face_ff <= pend_face_ff;
         out_hit_ff  <= 1'b1;
         out_last_ff <= 1'b0;
      end else if (emit_flush) begin
         out_dist_ff <= have_pend_ff ? pend_dist_ff : '0;
         out_face_ff <= have_pend_ff ? pend_face_ff : '0;
         out_hit_ff  <= have_pend_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign out_distance = out_dist_ff;
   assign out_face     = out_face_ff;
   assign out_hit      = out_hit_ff;
   assign out_last     = out_last_ff;
   assign out_valid    = out_valid_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_WAIT)
      else $error("divider finished outside the wait state");

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_hit_ff |-> out_last_ff)
      else $error("no-hit marker without last flag");

   a_flush_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH && out_free |=> state_ff == S_IDLE)
      else $error("flush did not return to idle");

   a_pend_face: assert property (@(posedge clock) disable iff (reset)
      have_pend_ff |-> pend_face_ff <= LAST_FACE)
      else $error("pending hit holds a bad face");

endmodule
`default_nettype wire

// File: hw/rtl/ray_box_face_intersection_core.sv
`default_nettype none
// Ray against axis-aligned box: each request transaction carries one ray (origin and
// direction, signed Q16.16) and is answered by one to six response transactions, one per
// face hit in the order x-low, x-high, y-low, y-high, z-low, z-high, the final one with
// tlast set; a ray that hits nothing gives a single marker with tuser clear. A front stage
// centres the ray and places it in a two-entry queue, so up to two further rays are taken
// while the back stage works. The back stage handles one face at a time with a bit-serial
// divider of 51 steps: a face whose axis has a non-zero direction passes through the select,
// divider-wait, multiply and test states in turn, while an axis with a zero direction has both
// its faces passed over from the select state; the ray is taken from the queue in the idle
// state, and the last response is issued from the flush state.
module ray_box_face_intersection_core import rbfi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Configuration: 0 size_x, 1 size_y, 2 size_z, 3 centred.
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_wr_data,
   // tdata, lowest bit up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [6*COORD_W-1:0] req_tdata,
   // tdata, lowest bit up: hit_distance [31:0], hit_face [34:32], zero padding.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata,
   // tuser: hit_valid. tlast: last_result.
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   ray_type           front_ray;
   ray_type           queue_ray;
   box_type           box;
   logic              queue_full;
   logic              queue_empty;
   logic              queue_pop;
   logic              req_accept;
   logic [COORD_W-1:0] distance;
   logic [FACE_W-1:0]  face;

   // The front stage needs only a free queue slot to take a transaction.
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   rbfi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .ray         (front_ray),
      .box         (box)
   );

   rbfi_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_ray),
      .pop       (queue_pop),
      .pop_data  (queue_ray),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // The back stage drives the response register directly; it holds while stalled.
   rbfi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .box          (box),
      .ray          (queue_ray),
      .ray_empty    (queue_empty),
      .ray_pop      (queue_pop),
      .out_distance (distance),
      .out_face     (face),
      .out_hit      (rsp_tuser),
      .out_last     (rsp_tlast),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready)
   );

   assign rsp_tdata = {5'b00000, face, distance};

endmodule
`default_nettype wire

// File: sim/ray_box_face_intersection_core_tb.sv
`default_nettype none
// Self-checking bench for the ray against axis-aligned box core. Rays are offered on the
// request stream and every response transaction is compared with the output of a local
// predictor of the face hits. The box sizes and the centre flag are changed between
// phases, only while the core is idle.
module ray_box_face_intersection_core_tb import rbfi_pkg::*;;

   typedef struct packed {
      logic [31:0] hit_dist;
      logic [2:0]  face;
      logic        hit;
      logic        last;
   } face_hit_type;

   // One row of the directed stimulus. When known is set, the single expected response
   // is typed into the row and the predictor must agree with it as well.
   typedef struct {
      logic [31:0]  o [3];
      logic [31:0]  d [3];
      bit           known;
      face_hit_type want;
   } ray_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_wr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [6*COORD_W-1:0] req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;

   ray_box_face_intersection_core u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The predictor keeps its own copy of the registers.
   logic [SIZE_W-1:0] box_size [3];
   logic              box_centred;

   face_hit_type pending_hits [$];
   int        mismatches = 0;
   int        cycle_count = 0;
   bit        sink_hold = 1'b0;     // long hold-off of the receiver
   bit        calm = 1'b0;          // stretch with no idling on either side

   localparam int CYCLE_LIMIT = 1_500_000;

   // Exact half-open test on one other axis: 0 <= p*2^F + t*d < s*2^F.
   function automatic bit on_face(longint p, longint t, longint d, longint s);
      logic signed [127:0] q;
      logic signed [127:0] lim;
      q   = (128'(signed'(p)) <<< FRAC_BITS) + 128'(signed'(t)) * 128'(signed'(d));
      lim = 128'(signed'(s)) <<< FRAC_BITS;
      return (q >= 0) && (q < lim);
   endfunction

   // Works out every face hit of one ray and appends them to the queue.
   task automatic predict_face_hits(input logic [31:0] o [3], input logic [31:0] d [3]);
      longint       p [3], dv [3], s [3];
      longint       num, t;
      int           b, c, n;
      face_hit_type h;
      n = 0;
      for (int a = 0; a < 3; a++) begin
         s[a]  = longint'(box_size[a]);
         p[a]  = longint'(signed'(o[a]));
         dv[a] = longint'(signed'(d[a]));
         if (box_centred) p[a] += s[a] >>> 1;
      end
      for (int a = 0; a < 3; a++) begin
         b = (a + 1) % 3;
         c = (a + 2) % 3;
         if (dv[a] == 0) continue;
         for (int f = 0; f < 2; f++) begin
            // The numerator times 2^16 stays well inside 64 bits.
            num = ((f != 0) ? s[a] : 0) - p[a];
            t   = (num * 65536) / dv[a];
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            if (on_face(p[b], t, dv[b], s[b]) && on_face(p[c], t, dv[c], s[c])) begin
               h.hit_dist = t[31:0];
               h.face     = 3'(a * 2 + f);
               h.hit      = 1'b1;
               h.last     = 1'b0;
               pending_hits.insert(pending_hits.size(), h);
               n++;
            end
         end
      end
      if (n == 0) begin
         h.hit_dist = '0;
         h.face     = '0;
         h.hit      = 1'b0;
         h.last     = 1'b1;
         pending_hits.insert(pending_hits.size(), h);
      end else begin
         pending_hits[$].last = 1'b1;
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_SIZE_X:  box_size[0] = val;
         CSR_SIZE_Y:  box_size[1] = val;
         CSR_SIZE_Z:  box_size[2] = val;
         CSR_CENTRED: box_centred = val[0];
         default: ;
      endcase
   endtask

   task automatic set_box(input logic [SIZE_W-1:0] sx, sy, sz, input bit cen);
      write_csr(CSR_SIZE_X, sx);
      write_csr(CSR_SIZE_Y, sy);
      write_csr(CSR_SIZE_Z, sz);
      write_csr(CSR_CENTRED, SIZE_W'(cen));
   endtask

   // Offers one ray and holds it until the request transaction completes. Valid stays
   // high after the accepting edge, so the next call can offer its ray at that same edge;
   // it is lowered only by an idle cycle or by the drain.
   task automatic send_ray(input logic [31:0] o [3], input logic [31:0] d [3]);
      while (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d[2], d[1], d[0], o[2], o[1], o[0]};
      predict_face_hits(o, d);
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering, waits for all responses, then pauses before returning.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // Random coordinate: mostly near the box, sometimes at full range.
   function automatic logic [31:0] rand_coord(input int span);
      case ($urandom_range(9))
         0:       return $urandom;
         1:       return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
         default: return 32'($signed($urandom_range(2 * span)) - span);
      endcase
   endfunction

   function automatic logic [31:0] rand_dir();
      case ($urandom_range(9))
         0:       return '0;
         1:       return $urandom;
         2:       return 32'($signed($urandom_range(64)) - 32);
         default: return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      endcase
   endfunction

   // Receiver: random stalls, and ready is sampled with the data at the edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !sink_hold && (calm || $urandom_range(99) >= 19);
      end
   end

   // Compares each response transaction with the oldest expected hit.
   always @(posedge clock) begin
      face_hit_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: dist %h face %0d hit %b last %b",
                        rsp_tdata[31:0], rsp_tdata[34:32], rsp_tuser, rsp_tlast);
         end else begin
            w = pending_hits.pop_front();
            if (rsp_tdata[31:0] !== w.hit_dist || rsp_tdata[34:32] !== w.face ||
                rsp_tdata[39:35] !== 5'b0 || rsp_tuser !== w.hit || rsp_tlast !== w.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want dist %h face %0d hit %b last %b, got %h %0d %b %b",
                           w.hit_dist, w.face, w.hit, w.last, rsp_tdata[31:0],
                           rsp_tdata[34:32], rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // Cycle counter ends a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Long hold-off of the receiver, counted in its own process, while rays keep coming.
   task automatic hold_receiver(input int cycles);
      sink_hold = 1'b1;
      repeat (cycles) @(posedge clock);
      sink_hold = 1'b0;
   endtask

   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] HALF = 32'h0000_8000;
   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;

   ray_row_type  rows [$];
   ray_row_type  r;
   face_hit_type miss;
   logic [31:0] o [3], d [3];

   function automatic ray_row_type mk(input logic [31:0] ox, oy, oz, dx, dy, dz, input bit k);
      ray_row_type x;
      x.o[0] = ox; x.o[1] = oy; x.o[2] = oz;
      x.d[0] = dx; x.d[1] = dy; x.d[2] = dz;
      x.known = k;
      x.want.hit_dist = '0; x.want.face = '0; x.want.hit = 1'b0; x.want.last = 1'b1;
      return x;
   endfunction

   initial begin
      box_size[0] = SIZE_RESET;
      box_size[1] = SIZE_RESET;
      box_size[2] = SIZE_RESET;
      box_centred = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, first with the reset unit box. Rows marked known expect the
      // no-hit marker: a zero direction skips every face.
      rows.insert(rows.size(), mk(HALF, HALF, HALF, 0, 0, 0, 1'b1));
      rows.insert(rows.size(), mk(MAXV, MINV, 0, 0, 0, 0, 1'b1));
      rows.insert(rows.size(), mk(MINV, HALF, HALF, ONE, 0, 0, 1'b0));
      rows.insert(rows.size(), mk(HALF, MINV, HALF, 0, ONE, 0, 1'b0));
      rows.insert(rows.size(), mk(HALF, HALF, MAXV, 0, 0, MINV, 1'b0));
      rows.insert(rows.size(), mk(HALF, HALF, HALF, ONE, ONE, ONE, 1'b0));
      rows.insert(rows.size(), mk(0, 0, 0, ONE, ONE, ONE, 1'b0));
      rows.insert(rows.size(), mk(ONE, ONE, ONE, MINV, MINV, MINV, 1'b0));
      rows.insert(rows.size(), mk(HALF, HALF, HALF, 1, 32'hffff_ffff, MAXV, 1'b0));
      rows.insert(rows.size(), mk(32'h0000_4000, HALF, HALF, 32'hffff_0000, 0, 0, 1'b0));
      rows.insert(rows.size(), mk(MAXV, MAXV, MAXV, 1, 1, 1, 1'b0));
      rows.insert(rows.size(), mk(MINV, MINV, MINV, MAXV, MAXV, MAXV, 1'b0));
      foreach (rows[i]) begin
         r = rows[i];
         if (r.known) begin
            predict_face_hits(r.o, r.d);
            miss = pending_hits.pop_back();
            if (miss != r.want) begin
               mismatches++;
               $display("directed row %0d: predictor disagrees with table", i);
            end
         end
         send_ray(r.o, r.d);
      end
      drain();

      // Extreme sizes, first centred and then not: zero size never passes, full size is huge.
      set_box('0, 31'h7fff_ffff, SIZE_RESET, 1'b1);
      foreach (rows[i]) send_ray(rows[i].o, rows[i].d);
      drain();
      set_box(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 1'b0);
      foreach (rows[i]) send_ray(rows[i].o, rows[i].d);
      drain();

      // Random phases with varied boxes; one phase is free of idling and one holds
      // the receiver off long enough for the request side to stall.
      for (int ph = 0; ph < 8; ph++) begin
         set_box(31'($urandom_range(32'h0004_0000)), 31'($urandom_range(32'h0004_0000)),
                 (ph == 5) ? 31'($urandom) : 31'($urandom_range(32'h0004_0000)),
                 1'($urandom_range(1)));
         calm = (ph == 3);
         if (ph == 2) fork hold_receiver(3000); join_none
         for (int k = 0; k < 47; k++) begin
            for (int a = 0; a < 3; a++) begin
               o[a] = rand_coord(32'h0003_0000);
               d[a] = rand_dir();
            end
            send_ray(o, d);
         end
         calm = 1'b0;
         drain();
      end
      set_box(SIZE_RESET, SIZE_RESET, SIZE_RESET, 1'b0);

      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
